@@ rtl/pilst_pkg.sv @@
package pilst_pkg;

   localparam int IDX_W = 10;
   localparam int NS_W  = 63;
   localparam int CNT_W = 64;

   localparam logic [NS_W-1:0] NS_MAX = {NS_W{1'b1}};

   localparam logic CSR_USE_WALL_CLOCK = 1'b0;
   localparam logic CSR_OVERHEAD_NS    = 1'b1;

   localparam logic REQ_RECORD = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DIFF,
      ST_OVH,
      ST_TOT,
      ST_CALL,
      ST_ERR,
      ST_MIN,
      ST_MAX,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic [CNT_W-1:0] calls;
      logic [CNT_W-1:0] errors;
      logic [NS_W-1:0]  total_ns;
      logic [NS_W-1:0]  min_ns;
      logic [NS_W-1:0]  max_ns;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{
      calls:    '0,
      errors:   '0,
      total_ns: '0,
      min_ns:   NS_MAX,
      max_ns:   '0
   };

endpackage

@@ rtl/pilst_ram.sv @@
module pilst_ram
   import pilst_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/per_index_latency_stats_table.sv @@
// per-index latency statistics table
// one entry per event index: call count, error count, saturating total,
// minimum and maximum latency in ns, held in one block ram
// req channel (valid/stall): req_type 0 records an event, 1 reads an entry
// rsp channel (valid/stall): one item per read, none per record
// a record item is taken, then a shared 64-bit add/subtract unit runs seven
// steps (difference, overhead, total, calls, errors, min, max), a write state
// puts the entry back, and only then is the next item taken
// a read item is taken into a read state whose result is registered onto rsp
// once the result register is free, and the next item is not taken before
// then; out-of-range reads return in_range low with all other fields zero
// out-of-range record items are dropped in the cycle they are taken
// after reset the ram is swept one entry a cycle, through all NUM_ENTRIES
// entries, with req_stall high; csr writes are taken at any time
// while rsp is stalled the result register holds; record items still go on,
// a further read waits until the held item is taken
module per_index_latency_stats_table
   import pilst_pkg::*;
#(
   parameter int NUM_ENTRIES = 512
) (
   input  logic             clock,
   input  logic             reset,

   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [NS_W-1:0]  csr_wdata,

   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_type,
   input  logic [IDX_W-1:0] req_event_index,
   input  logic             req_is_error,
   input  logic [NS_W-1:0]  req_start_wall_ns,
   input  logic [NS_W-1:0]  req_end_wall_ns,
   input  logic [NS_W-1:0]  req_start_cpu_ns,
   input  logic [NS_W-1:0]  req_end_cpu_ns,

   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_in_range,
   output logic [CNT_W-1:0] rsp_call_count,
   output logic [CNT_W-1:0] rsp_error_count,
   output logic [NS_W-1:0]  rsp_total_ns,
   output logic [NS_W-1:0]  rsp_min_ns,
   output logic [NS_W-1:0]  rsp_max_ns
);

   localparam int AW = $clog2(NUM_ENTRIES);
   localparam int EW = $bits(entry_type);

   state_type        state_ff, state_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic             use_wall_ff, use_wall_in;
   logic [NS_W-1:0]  overhead_ff, overhead_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic             err_ff, err_in;
   logic [NS_W-1:0]  start_ff, start_in;
   logic [NS_W-1:0]  end_ff, end_in;
   logic             neg_ff, neg_in;
   logic [NS_W-1:0]  lat_ff, lat_in;
   logic             in_range_ff, in_range_in;
   entry_type        ent_ff, ent_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_in_range_ff, rsp_in_range_in;
   entry_type        rsp_ent_ff, rsp_ent_in;

   logic             req_take;
   logic             req_ok;
   logic             rsp_free;

   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   entry_type        ram_wdata;
   logic             ram_re;
   entry_type        ram_rdata;
   logic [EW-1:0]    ram_rdata_bits;

   logic [CNT_W-1:0] unit_a;
   logic [CNT_W-1:0] unit_b;
   logic             unit_sub;
   logic [CNT_W:0]   unit_sum;
   logic             unit_borrow;

   assign req_take = req_valid && !req_stall;
   assign req_ok   = {1'b0, req_event_index} < (IDX_W + 1)'(NUM_ENTRIES);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // shared add/subtract unit
   assign unit_sum = {1'b0, unit_a} + {1'b0, (unit_sub ? ~unit_b : unit_b)}
                     + (CNT_W + 1)'(unit_sub);
   assign unit_borrow = !unit_sum[CNT_W];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(NUM_ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               if (req_type == REQ_READ) begin
                  state_in = ST_READ;
               end else if (req_ok) begin
                  state_in = ST_DIFF;
               end
            end
         end
         ST_READ: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIFF:  state_in = ST_OVH;
         ST_OVH:   state_in = ST_TOT;
         ST_TOT:   state_in = ST_CALL;
         ST_CALL:  state_in = ST_ERR;
         ST_ERR:   state_in = ST_MIN;
         ST_MIN:   state_in = ST_MAX;
         ST_MAX:   state_in = ST_WRITE;
         ST_WRITE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = ent_ff;
      ram_re    = 1'b0;
      unit_a    = '0;
      unit_b    = '0;
      unit_sub  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = ENTRY_RESET;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            ram_re    = req_valid;
         end
         ST_DIFF: begin
            unit_a   = {1'b0, end_ff};
            unit_b   = {1'b0, start_ff};
            unit_sub = 1'b1;
         end
         ST_OVH: begin
            unit_a   = {1'b0, lat_ff};
            unit_b   = {1'b0, overhead_ff};
            unit_sub = 1'b1;
         end
         ST_TOT: begin
            unit_a = {1'b0, ent_ff.total_ns};
            unit_b = {1'b0, lat_ff};
         end
         ST_CALL: begin
            unit_a = ent_ff.calls;
            unit_b = CNT_W'(1);
         end
         ST_ERR: begin
            unit_a = ent_ff.errors;
            unit_b = CNT_W'(err_ff);
         end
         ST_MIN: begin
            unit_a   = {1'b0, lat_ff};
            unit_b   = {1'b0, ent_ff.min_ns};
            unit_sub = 1'b1;
         end
         ST_MAX: begin
            unit_a   = {1'b0, ent_ff.max_ns};
            unit_b   = {1'b0, lat_ff};
            unit_sub = 1'b1;
         end
         ST_WRITE: begin
            ram_we = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      clr_in          = clr_ff;
      use_wall_in     = use_wall_ff;
      overhead_in     = overhead_ff;
      idx_in          = idx_ff;
      err_in          = err_ff;
      start_in        = start_ff;
      end_in          = end_ff;
      neg_in          = neg_ff;
      lat_in          = lat_ff;
      in_range_in     = in_range_ff;
      ent_in          = ent_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_in_range_in = rsp_in_range_ff;
      rsp_ent_in      = rsp_ent_ff;

      if (csr_we) begin
         if (csr_index == CSR_USE_WALL_CLOCK) begin
            use_wall_in = csr_wdata[0];
         end else begin
            overhead_in = csr_wdata;
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            idx_in      = req_event_index[AW-1:0];
            err_in      = req_is_error;
            in_range_in = req_ok;
            start_in    = use_wall_ff ? req_start_wall_ns : req_start_cpu_ns;
            end_in      = use_wall_ff ? req_end_wall_ns : req_end_cpu_ns;
         end
         ST_READ: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in_range_in = in_range_ff;
               rsp_ent_in      = in_range_ff ? ram_rdata : '0;
            end
         end
         ST_DIFF: begin
            ent_in = ram_rdata;
            neg_in = unit_borrow;
            lat_in = unit_sum[NS_W-1:0];
         end
         ST_OVH: begin
            lat_in = (neg_ff || unit_borrow) ? '0 : unit_sum[NS_W-1:0];
         end
         ST_TOT: begin
            ent_in.total_ns = unit_sum[NS_W] ? NS_MAX : unit_sum[NS_W-1:0];
         end
         ST_CALL: begin
            ent_in.calls = unit_sum[CNT_W-1:0];
         end
         ST_ERR: begin
            ent_in.errors = unit_sum[CNT_W-1:0];
         end
         ST_MIN: begin
            if (unit_borrow) begin
               ent_in.min_ns = lat_ff;
            end
         end
         ST_MAX: begin
            if (unit_borrow) begin
               ent_in.max_ns = lat_ff;
            end
         end
         default: begin
            clr_in = clr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         use_wall_ff  <= 1'b0;
         overhead_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         use_wall_ff  <= use_wall_in;
         overhead_ff  <= overhead_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff          <= idx_in;
      err_ff          <= err_in;
      start_ff        <= start_in;
      end_ff          <= end_in;
      neg_ff          <= neg_in;
      lat_ff          <= lat_in;
      in_range_ff     <= in_range_in;
      ent_ff          <= ent_in;
      rsp_in_range_ff <= rsp_in_range_in;
      rsp_ent_ff      <= rsp_ent_in;
   end

   pilst_ram #(
      .WIDTH (EW),
      .DEPTH (NUM_ENTRIES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (req_event_index[AW-1:0]),
      .rdata (ram_rdata_bits)
   );

   assign ram_rdata = ram_rdata_bits;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_in_range    = rsp_in_range_ff;
   assign rsp_call_count  = rsp_ent_ff.calls;
   assign rsp_error_count = rsp_ent_ff.errors;
   assign rsp_total_ns    = rsp_ent_ff.total_ns;
   assign rsp_min_ns      = rsp_ent_ff.min_ns;
   assign rsp_max_ns      = rsp_ent_ff.max_ns;

`ifndef SYNTHESIS
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_READ))
      else $error("result raised outside a read");

   a_min_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (ent_ff.min_ns <= lat_ff && ent_ff.max_ns >= lat_ff))
      else $error("min or max not folded with latency");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (ent_ff.total_ns >= lat_ff))
      else $error("total below latency of this item");

   a_clear_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (32'(clr_ff) < NUM_ENTRIES && req_stall))
      else $error("clear sweep out of range or open to items");
`endif

endmodule

@@ verif/tb_per_index_latency_stats_table.sv @@
`timescale 1ns / 1ps

module tb_per_index_latency_stats_table
   import pilst_pkg::*;
;

   localparam int NUM_ENTRIES  = 512;
   localparam int RANDOM_ITEMS = 1600;
   localparam int CHUNKS       = 6;
   localparam int SETTLE       = 16;

   typedef struct packed {
      logic             kind;
      logic [IDX_W-1:0] index;
      logic             is_error;
      logic [NS_W-1:0]  start_wall;
      logic [NS_W-1:0]  end_wall;
      logic [NS_W-1:0]  start_cpu;
      logic [NS_W-1:0]  end_cpu;
   } stats_req_type;

   typedef struct packed {
      logic             in_range;
      logic [CNT_W-1:0] calls;
      logic [CNT_W-1:0] errors;
      logic [NS_W-1:0]  total_ns;
      logic [NS_W-1:0]  min_ns;
      logic [NS_W-1:0]  max_ns;
   } entry_read_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we = 1'b0;
   logic             csr_index = CSR_USE_WALL_CLOCK;
   logic [NS_W-1:0]  csr_wdata = '0;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic             req_type = REQ_RECORD;
   logic [IDX_W-1:0] req_event_index = '0;
   logic             req_is_error = 1'b0;
   logic [NS_W-1:0]  req_start_wall_ns = '0;
   logic [NS_W-1:0]  req_end_wall_ns = '0;
   logic [NS_W-1:0]  req_start_cpu_ns = '0;
   logic [NS_W-1:0]  req_end_cpu_ns = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_in_range;
   logic [CNT_W-1:0] rsp_call_count;
   logic [CNT_W-1:0] rsp_error_count;
   logic [NS_W-1:0]  rsp_total_ns;
   logic [NS_W-1:0]  rsp_min_ns;
   logic [NS_W-1:0]  rsp_max_ns;

   stats_req_type  pending_q[$];
   stats_req_type  cur_req;
   entry_read_type entry_read_q[$];

   logic [CNT_W-1:0] calls_tab  [NUM_ENTRIES];
   logic [CNT_W-1:0] errors_tab [NUM_ENTRIES];
   logic [NS_W-1:0]  total_tab  [NUM_ENTRIES];
   logic [NS_W-1:0]  min_tab    [NUM_ENTRIES];
   logic [NS_W-1:0]  max_tab    [NUM_ENTRIES];
   logic             wall_mode = 1'b0;
   logic [NS_W-1:0]  overhead = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int fail_count = 0;

   always #10 clock = ~clock;

   per_index_latency_stats_table #(
      .NUM_ENTRIES(NUM_ENTRIES)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_event_index  (req_event_index),
      .req_is_error     (req_is_error),
      .req_start_wall_ns(req_start_wall_ns),
      .req_end_wall_ns  (req_end_wall_ns),
      .req_start_cpu_ns (req_start_cpu_ns),
      .req_end_cpu_ns   (req_end_cpu_ns),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_in_range     (rsp_in_range),
      .rsp_call_count   (rsp_call_count),
      .rsp_error_count  (rsp_error_count),
      .rsp_total_ns     (rsp_total_ns),
      .rsp_min_ns       (rsp_min_ns),
      .rsp_max_ns       (rsp_max_ns)
   );

   function automatic logic [NS_W-1:0] rand_ns();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[NS_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] rand_index();
      case ($urandom_range(9))
         0: return IDX_W'($urandom_range(NUM_ENTRIES - 1, NUM_ENTRIES - 16));
         1: return IDX_W'($urandom_range((2 ** IDX_W) - 1, NUM_ENTRIES));
         2: return IDX_W'($urandom_range((2 ** IDX_W) - 1));
         default: return IDX_W'($urandom_range(15));
      endcase
   endfunction

   function automatic void rand_span(output logic [NS_W-1:0] t0, output logic [NS_W-1:0] t1);
      case ($urandom_range(9))
         0: begin
            t0 = rand_ns();
            t1 = rand_ns();
         end
         1: begin
            t0 = '0;
            t1 = NS_MAX - NS_W'($urandom_range(3));
         end
         2: begin
            t0 = NS_MAX;
            t1 = $urandom_range(1) ? NS_MAX : '0;
         end
         3: begin
            // end at or before start
            t1 = rand_ns() >> $urandom_range(NS_W - 1);
            t0 = t1 + NS_W'($urandom_range(5000));
         end
         default: begin
            t0 = rand_ns() >> $urandom_range(NS_W - 1);
            t1 = t0 + NS_W'($urandom_range(20000));
         end
      endcase
   endfunction

   function automatic void push_req(logic kind, logic [IDX_W-1:0] index, logic is_error,
                                    logic [NS_W-1:0] sw, logic [NS_W-1:0] ew,
                                    logic [NS_W-1:0] sc, logic [NS_W-1:0] ec);
      stats_req_type r;
      r.kind       = kind;
      r.index      = index;
      r.is_error   = is_error;
      r.start_wall = sw;
      r.end_wall   = ew;
      r.start_cpu  = sc;
      r.end_cpu    = ec;
      pending_q.push_back(r);
   endfunction

   function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                       logic [CNT_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic write_csr(logic index, logic [NS_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CSR_USE_WALL_CLOCK) begin
         wall_mode = value[0];
      end else begin
         overhead = value;
      end
   endtask

   // block idle: nothing queued, nothing presented, no read outstanding
   task automatic drain();
      @(negedge clock);
      while (pending_q.size() != 0 || req_valid || entry_read_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   // driver and statistics prediction
   always @(posedge clock) begin : drv
      logic [NS_W-1:0] t0, t1, lat;
      int unsigned     slot;
      entry_read_type  rd;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            slot = 32'(cur_req.index);
            if (cur_req.kind == REQ_READ) begin
               rd = '0;
               if (slot < NUM_ENTRIES) begin
                  rd.in_range = 1'b1;
                  rd.calls    = calls_tab[slot];
                  rd.errors   = errors_tab[slot];
                  rd.total_ns = total_tab[slot];
                  rd.min_ns   = min_tab[slot];
                  rd.max_ns   = max_tab[slot];
               end
               entry_read_q.push_back(rd);
            end else if (slot < NUM_ENTRIES) begin
               t0  = wall_mode ? cur_req.start_wall : cur_req.start_cpu;
               t1  = wall_mode ? cur_req.end_wall : cur_req.end_cpu;
               lat = '0;
               if (t1 > t0 && t1 - t0 > overhead) begin
                  lat = t1 - t0 - overhead;
               end
               calls_tab[slot] = calls_tab[slot] + CNT_W'(1);
               if (cur_req.is_error) begin
                  errors_tab[slot] = errors_tab[slot] + CNT_W'(1);
               end
               if (lat > NS_MAX - total_tab[slot]) begin
                  total_tab[slot] = NS_MAX;
               end else begin
                  total_tab[slot] = total_tab[slot] + lat;
               end
               if (lat < min_tab[slot]) begin
                  min_tab[slot] = lat;
               end
               if (lat > max_tab[slot]) begin
                  max_tab[slot] = lat;
               end
            end
         end
         if (!req_valid || !req_stall) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_req = pending_q.pop_front();
               req_valid         <= 1'b1;
               req_type          <= cur_req.kind;
               req_event_index   <= cur_req.index;
               req_is_error      <= cur_req.is_error;
               req_start_wall_ns <= cur_req.start_wall;
               req_end_wall_ns   <= cur_req.end_wall;
               req_start_cpu_ns  <= cur_req.start_cpu;
               req_end_cpu_ns    <= cur_req.end_cpu;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : mon
      entry_read_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (entry_read_q.size() == 0) begin
               $error("result item with no read outstanding");
               fail_count++;
            end else begin
               want = entry_read_q.pop_front();
               check_field("in_range", CNT_W'(want.in_range), CNT_W'(rsp_in_range));
               check_field("call_count", want.calls, rsp_call_count);
               check_field("error_count", want.errors, rsp_error_count);
               check_field("total_ns", CNT_W'(want.total_ns), CNT_W'(rsp_total_ns));
               check_field("min_ns", CNT_W'(want.min_ns), CNT_W'(rsp_min_ns));
               check_field("max_ns", CNT_W'(want.max_ns), CNT_W'(rsp_max_ns));
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   initial begin
      logic [NS_W-1:0] sw, ew, sc, ec;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         calls_tab[i]  = '0;
         errors_tab[i] = '0;
         total_tab[i]  = '0;
         min_tab[i]    = NS_MAX;
         max_tab[i]    = '0;
      end
      send_idle_pct = 37;
      recv_idle_pct = 49;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // cpu time, no overhead
      push_req(REQ_READ, 0, 1'b0, '0, '0, '0, '0);
      push_req(REQ_READ, IDX_W'((2 ** IDX_W) - 1), 1'b1, NS_MAX, NS_MAX, NS_MAX, NS_MAX);
      push_req(REQ_READ, IDX_W'(NUM_ENTRIES), 1'b0, '0, '0, '0, '0);
      push_req(REQ_RECORD, IDX_W'(NUM_ENTRIES - 1), 1'b1, '0, '0, '0, NS_MAX);
      push_req(REQ_RECORD, IDX_W'(NUM_ENTRIES - 1), 1'b0, NS_MAX, '0, 1, NS_MAX);
      push_req(REQ_READ, IDX_W'(NUM_ENTRIES - 1), 1'b0, '0, '0, '0, '0);
      push_req(REQ_RECORD, 700, 1'b1, '0, 100, '0, 100);
      push_req(REQ_RECORD, IDX_W'((2 ** IDX_W) - 1), 1'b1, '0, NS_MAX, '0, NS_MAX);
      push_req(REQ_RECORD, 0, 1'b0, '0, NS_MAX, 500, 200);
      push_req(REQ_RECORD, 0, 1'b1, '0, '0, 100, 350);
      push_req(REQ_READ, 0, 1'b0, '0, '0, '0, '0);
      drain();

      // wall clock with overhead
      write_csr(CSR_USE_WALL_CLOCK, NS_MAX);
      write_csr(CSR_OVERHEAD_NS, 1000);
      push_req(REQ_RECORD, 2, 1'b0, 10, 510, '0, NS_MAX);
      push_req(REQ_RECORD, 2, 1'b0, 10, 1010, '0, '0);
      push_req(REQ_RECORD, 2, 1'b1, 10, 5010, '0, '0);
      push_req(REQ_RECORD, 2, 1'b0, 5000, 4000, '0, '0);
      push_req(REQ_READ, 2, 1'b0, '0, '0, '0, '0);
      drain();
      write_csr(CSR_OVERHEAD_NS, NS_MAX);
      push_req(REQ_RECORD, 3, 1'b0, '0, NS_MAX, '0, NS_MAX);
      push_req(REQ_READ, 3, 1'b0, '0, '0, '0, '0);

      for (int c = 0; c < CHUNKS; c++) begin
         drain();
         send_idle_pct = (c < 2) ? 37 : (c < 4) ? 49 : 0;
         recv_idle_pct = (c < 2) ? 49 : (c < 4) ? 37 : 0;
         case (c)
            0: begin
               write_csr(CSR_USE_WALL_CLOCK, '0);
               write_csr(CSR_OVERHEAD_NS, '0);
            end
            1: begin
               write_csr(CSR_USE_WALL_CLOCK, 1);
               write_csr(CSR_OVERHEAD_NS, rand_ns() >> $urandom_range(NS_W - 1));
            end
            2: begin
               write_csr(CSR_USE_WALL_CLOCK, 1);
               write_csr(CSR_OVERHEAD_NS, NS_W'($urandom_range(5000)));
            end
            3: begin
               write_csr(CSR_USE_WALL_CLOCK, '0);
               write_csr(CSR_OVERHEAD_NS, rand_ns());
            end
            4: begin
               write_csr(CSR_USE_WALL_CLOCK, 1);
               write_csr(CSR_OVERHEAD_NS, '0);
            end
            default: begin
               write_csr(CSR_USE_WALL_CLOCK, '0);
               write_csr(CSR_OVERHEAD_NS, NS_W'($urandom_range(20000)));
            end
         endcase
         repeat (RANDOM_ITEMS / CHUNKS) begin
            rand_span(sw, ew);
            rand_span(sc, ec);
            push_req(($urandom_range(99) < 35) ? REQ_READ : REQ_RECORD, rand_index(),
                     1'($urandom_range(1)), sw, ew, sc, ec);
         end
      end
      drain();

      if (fail_count == 0) begin
         $display("** per_index_latency_stats_table: PASSED **");
      end else begin
         $display("** per_index_latency_stats_table: FAILED **");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("** per_index_latency_stats_table: FAILED **");
      $finish;
   end

endmodule

@@ per_index_latency_stats_table.f @@
rtl/pilst_pkg.sv
rtl/pilst_ram.sv
rtl/per_index_latency_stats_table.sv
verif/tb_per_index_latency_stats_table.sv
